// ===== rtl/core/gbp_pkg.sv =====
package gbp_pkg;

    localparam int INDEX_BITS_DFLT = 10;
    localparam int HB_W            = 4;   // history length register width
    localparam int COUNT_W         = 32;

    localparam logic [1:0] CTR_WEAK_TAKEN = 2'd2;
    localparam logic [1:0] CTR_MAX        = 2'd3;
    localparam logic [1:0] CTR_MIN        = 2'd0;

    typedef enum logic {
        ST_CLEAR,
        ST_RUN
    } t_init_state;

    // Beat moving from the index stage to the update stage
    typedef struct packed {
        logic valid;
        logic taken;
    } t_beat_ctl;

    function automatic logic [1:0] ctr_step(input logic [1:0] ctr, input logic taken);
        logic [1:0] res;
        res = ctr;
        if (taken) begin
            if (ctr != CTR_MAX) res = ctr + 2'd1;
        end else begin
            if (ctr != CTR_MIN) res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/gbp_pht.sv =====
module gbp_pht #(
    parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DFLT
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [INDEX_BITS-1:0] i_wr_addr,
    input  logic [1:0]            i_wr_data,
    input  logic                  i_rd_en,
    input  logic [INDEX_BITS-1:0] i_rd_addr,
    output logic [1:0]            o_rd_data
);
    import gbp_pkg::*;

    localparam int DEPTH = 1 << INDEX_BITS;

    logic [1:0] r_mem [DEPTH];
    logic [1:0] r_rd_data;

    // read returns old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/gbp_front.sv =====
module gbp_front #(
    parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DFLT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gbp_pkg::HB_W-1:0]  i_cfg_wdata,
    input  logic                      i_accept,
    input  logic [63:0]               i_branch_address,
    input  logic                      i_taken,
    input  logic                      i_advance,
    output logic                      o_rd_en,
    output logic [INDEX_BITS-1:0]     o_rd_addr,
    output gbp_pkg::t_beat_ctl        o_s1,
    output logic [INDEX_BITS-1:0]     o_s1_idx
);
    import gbp_pkg::*;

    localparam int SH_W = $clog2(INDEX_BITS + 1);

    logic [HB_W-1:0]       r_hbits;
    logic [INDEX_BITS-1:0] r_hist, n_hist;
    logic                  r_s1_valid, n_s1_valid;
    logic                  r_s1_taken;
    logic [INDEX_BITS-1:0] r_s1_idx;

    logic [SH_W-1:0]       hist_sh;
    logic [INDEX_BITS-1:0] idx;
    logic [INDEX_BITS-1:0] hist_set;

    // history length clamps to the index width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hbits <= '0;
        end else if (i_cfg_we) begin
            if (32'(i_cfg_wdata) > 32'(INDEX_BITS)) begin
                r_hbits <= HB_W'(INDEX_BITS);
            end else begin
                r_hbits <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        hist_sh  = SH_W'(INDEX_BITS) - SH_W'(r_hbits);
        idx      = i_branch_address[2 +: INDEX_BITS] ^ (r_hist << hist_sh);
        hist_set = i_taken ? (INDEX_BITS'(1) << (r_hbits - HB_W'(1))) : '0;
        n_hist   = r_hist;
        if (i_accept && (r_hbits != '0)) begin
            n_hist = (r_hist >> 1) | hist_set;
        end
        n_s1_valid = r_s1_valid;
        if (i_accept) begin
            n_s1_valid = 1'b1;
        end else if (i_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_hist     <= n_hist;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_idx   <= idx;
            r_s1_taken <= i_taken;
        end
    end

    assign o_rd_en        = i_accept;
    assign o_rd_addr      = idx;
    assign o_s1.valid     = r_s1_valid;
    assign o_s1.taken     = r_s1_taken;
    assign o_s1_idx       = r_s1_idx;

endmodule

// ===== rtl/core/gbp_back.sv =====
module gbp_back #(
    parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gbp_pkg::t_beat_ctl           i_s1,
    input  logic [INDEX_BITS-1:0]        i_s1_idx,
    input  logic [1:0]                   i_rd_data,
    output logic                         o_advance,
    output logic                         o_wr_en,
    output logic [INDEX_BITS-1:0]        o_wr_addr,
    output logic [1:0]                   o_wr_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_predicted_taken,
    output logic                         o_mispredicted,
    output logic [gbp_pkg::COUNT_W-1:0]  o_mispredict_total,
    output logic [gbp_pkg::COUNT_W-1:0]  o_branch_total
);
    import gbp_pkg::*;

    logic                  r_fwd_valid;
    logic [INDEX_BITS-1:0] r_fwd_idx;
    logic [1:0]            r_fwd_val;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_pred;
    logic                  r_out_miss;
    logic [COUNT_W-1:0]    r_miss, n_miss;
    logic [COUNT_W-1:0]    r_seen, n_seen;

    logic       advance;
    logic [1:0] ctr;
    logic       pred;
    logic       miss;

    // last write bypasses the memory read that overlapped it
    always_comb begin
        ctr     = (r_fwd_valid && (r_fwd_idx == i_s1_idx)) ? r_fwd_val : i_rd_data;
        pred    = ctr[1];
        miss    = pred != i_s1.taken;
        advance = i_s1.valid && (!r_out_valid || i_out_ready);

        n_seen = r_seen;
        n_miss = r_miss;
        if (advance) begin
            if (r_seen != '1) n_seen = r_seen + COUNT_W'(1);
            if (miss && (r_miss != '1)) n_miss = r_miss + COUNT_W'(1);
        end

        n_out_valid = r_out_valid;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_seen      <= '0;
            r_miss      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_seen      <= n_seen;
            r_miss      <= n_miss;
            if (advance) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_fwd_idx  <= i_s1_idx;
            r_fwd_val  <= ctr_step(ctr, i_s1.taken);
            r_out_pred <= pred;
            r_out_miss <= miss;
        end
    end

    assign o_advance          = advance;
    assign o_wr_en            = advance;
    assign o_wr_addr          = i_s1_idx;
    assign o_wr_data          = ctr_step(ctr, i_s1.taken);
    assign o_out_valid        = r_out_valid;
    assign o_predicted_taken  = r_out_pred;
    assign o_mispredicted     = r_out_miss;
    assign o_mispredict_total = r_miss;
    assign o_branch_total     = r_seen;

    a_miss_le_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss <= r_seen)
        else $error("mispredict count above branch count");

    a_seen_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_seen == $past(r_seen) + COUNT_W'(1)) || ($past(r_seen) == '1))
        else $error("branch count did not step on a retired beat");

    a_hold_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_seen) && $stable(r_miss))
        else $error("counts moved without a retired beat");

    a_fwd_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_fwd_valid && (r_fwd_idx == $past(i_s1_idx)))
        else $error("bypass register missed the last table write");

endmodule

// ===== rtl/core/gshare_branch_predictor.sv =====
// Channel  Handshake                  Payload
// -------  -------------------------  ----------------------------------------------
// in       i_in_valid / o_in_ready    i_branch_address[63:0], i_taken
// out      o_out_valid / i_out_ready  o_predicted_taken, o_mispredicted,
//                                     o_mispredict_total[31:0], o_branch_total[31:0]
// cfg      i_cfg_we                   i_cfg_wdata[3:0] (history length)
//
// One beat a cycle sustained while the output is not stalled; a result passes the
// table read register, then the update stage into the output register. The counter
// table read is a registered stage of its own. After reset the table is swept to
// weakly taken, one entry a cycle; o_in_ready stays low meanwhile. Config writes
// are taken. A stalled output holds the update stage; the input side keeps flowing
// while that stage can empty into the output register in the same cycle.
module gshare_branch_predictor #(
    parameter int INDEX_BITS = gbp_pkg::INDEX_BITS_DFLT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gbp_pkg::HB_W-1:0]     i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [63:0]                  i_branch_address,
    input  logic                         i_taken,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_predicted_taken,
    output logic                         o_mispredicted,
    output logic [gbp_pkg::COUNT_W-1:0]  o_mispredict_total,
    output logic [gbp_pkg::COUNT_W-1:0]  o_branch_total
);
    import gbp_pkg::*;

    t_init_state           r_state, n_state;
    logic [INDEX_BITS-1:0] r_clr_addr, n_clr_addr;
    logic                  clearing;

    logic                  accept;
    logic                  advance;
    logic                  rd_en;
    logic [INDEX_BITS-1:0] rd_addr;
    logic [1:0]            rd_data;
    t_beat_ctl             s1;
    logic [INDEX_BITS-1:0] s1_idx;

    logic                  upd_wr_en;
    logic [INDEX_BITS-1:0] upd_wr_addr;
    logic [1:0]            upd_wr_data;

    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [1:0]            wr_data;

    // reset sweep: next state
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + INDEX_BITS'(1);
                if (r_clr_addr == '1) n_state = ST_RUN;
            end
            ST_RUN: begin
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // reset sweep: outputs
    always_comb begin
        case (r_state)
            ST_CLEAR: clearing = 1'b1;
            ST_RUN:   clearing = 1'b0;
            default:  clearing = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
        end
    end

    // outside the reset sweep, a new beat enters whenever the update stage is empty or emptying
    assign o_in_ready = !clearing && (!s1.valid || advance);
    assign accept     = i_in_valid && o_in_ready;

    assign wr_en   = clearing ? 1'b1 : upd_wr_en;
    assign wr_addr = clearing ? r_clr_addr : upd_wr_addr;
    assign wr_data = clearing ? CTR_WEAK_TAKEN : upd_wr_data;

    gbp_front #(
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_accept         (accept),
        .i_branch_address (i_branch_address),
        .i_taken          (i_taken),
        .i_advance        (advance),
        .o_rd_en          (rd_en),
        .o_rd_addr        (rd_addr),
        .o_s1             (s1),
        .o_s1_idx         (s1_idx)
    );

    gbp_pht #(
        .INDEX_BITS (INDEX_BITS)
    ) u_pht (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    gbp_back #(
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_s1               (s1),
        .i_s1_idx           (s1_idx),
        .i_rd_data          (rd_data),
        .o_advance          (advance),
        .o_wr_en            (upd_wr_en),
        .o_wr_addr          (upd_wr_addr),
        .o_wr_data          (upd_wr_data),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_predicted_taken  (o_predicted_taken),
        .o_mispredicted     (o_mispredicted),
        .o_mispredict_total (o_mispredict_total),
        .o_branch_total     (o_branch_total)
    );

    a_no_beat_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !o_in_ready && !s1.valid)
        else $error("beat admitted during table sweep");

    a_sweep_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !upd_wr_en)
        else $error("update write during table sweep");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> s1.valid)
        else $error("accepted beat lost before update stage");

endmodule
